@@ rtl/pvse_pkg.sv @@
// shared types, constants and the sample-to-setting map of the pulse/volume encoder
`default_nettype none

package pvse_pkg;

  localparam int unsigned SampleW = 8;
  localparam int unsigned PulseW  = 4;
  localparam int unsigned VolW    = 3;

  localparam logic [7:0] MidLow   = 8'd127;
  localparam logic [7:0] MidHigh  = 8'd128;
  localparam logic [7:0] ThrUp    = 8'd16;
  localparam logic [7:0] ThrDown  = 8'd240;
  localparam logic [3:0] PulseMin = 4'd0;
  localparam logic [3:0] PulseMax = 4'd15;
  localparam logic [2:0] VolMax   = 3'd7;

  typedef struct packed {
    logic [PulseW-1:0] pulse;
    logic [VolW-1:0]   vol;
  } cfg_t;

  typedef struct packed {
    logic valid;
    cfg_t cfg;
  } stage_t;

  function automatic cfg_t mk(input logic [3:0] p, input logic [2:0] v);
    cfg_t c;
    c.pulse = p;
    c.vol   = v;
    return c;
  endfunction

  // ranges in table order; the ranges do not overlap, so 210 and 211 fall in 208 to 211 only
  function automatic cfg_t map_sample(input logic [SampleW-1:0] s);
    cfg_t c;
    unique case (s) inside
      [8'd0:8'd14]:    c = mk(4'd0, 3'd7);
      [8'd15:8'd17]:   c = mk(4'd0, 3'd6);
      [8'd18:8'd30]:   c = mk(4'd1, 3'd7);
      [8'd31:8'd35]:   c = mk(4'd1, 3'd6);
      [8'd36:8'd44]:   c = mk(4'd2, 3'd7);
      [8'd45:8'd46]:   c = mk(4'd1, 3'd5);
      [8'd47:8'd53]:   c = mk(4'd2, 3'd6);
      [8'd54:8'd57]:   c = mk(4'd3, 3'd7);
      [8'd58:8'd62]:   c = mk(4'd2, 3'd5);
      [8'd63:8'd69]:   c = mk(4'd3, 3'd6);
      [8'd70:8'd71]:   c = mk(4'd2, 3'd4);
      [8'd72:8'd78]:   c = mk(4'd3, 3'd5);
      [8'd79:8'd80]:   c = mk(4'd4, 3'd6);
      [8'd81:8'd85]:   c = mk(4'd3, 3'd4);
      [8'd86:8'd89]:   c = mk(4'd4, 3'd5);
      [8'd90:8'd91]:   c = mk(4'd5, 3'd7);
      [8'd92:8'd94]:   c = mk(4'd4, 3'd4);
      [8'd95:8'd98]:   c = mk(4'd5, 3'd6);
      [8'd99:8'd103]:  c = mk(4'd5, 3'd5);
      [8'd104:8'd105]: c = mk(4'd5, 3'd4);
      [8'd106:8'd107]: c = mk(4'd4, 3'd2);
      [8'd108:8'd110]: c = mk(4'd6, 3'd7);
      [8'd111:8'd112]: c = mk(4'd6, 3'd6);
      [8'd113:8'd114]: c = mk(4'd6, 3'd5);
      [8'd115:8'd116]: c = mk(4'd6, 3'd4);
      [8'd117:8'd119]: c = mk(4'd6, 3'd3);
      [8'd120:8'd121]: c = mk(4'd6, 3'd2);
      [8'd122:8'd123]: c = mk(4'd6, 3'd1);
      [8'd124:8'd126]: c = mk(4'd6, 3'd0);
      [8'd127:8'd127]: c = mk(4'd7, 3'd0);
      [8'd128:8'd128]: c = mk(4'd8, 3'd0);
      [8'd129:8'd130]: c = mk(4'd9, 3'd0);
      [8'd131:8'd132]: c = mk(4'd9, 3'd1);
      [8'd133:8'd134]: c = mk(4'd9, 3'd2);
      [8'd135:8'd137]: c = mk(4'd9, 3'd3);
      [8'd138:8'd139]: c = mk(4'd9, 3'd4);
      [8'd140:8'd141]: c = mk(4'd9, 3'd5);
      [8'd142:8'd143]: c = mk(4'd9, 3'd6);
      [8'd144:8'd146]: c = mk(4'd9, 3'd7);
      [8'd147:8'd148]: c = mk(4'd11, 3'd2);
      [8'd149:8'd150]: c = mk(4'd10, 3'd4);
      [8'd151:8'd155]: c = mk(4'd10, 3'd5);
      [8'd156:8'd159]: c = mk(4'd10, 3'd6);
      [8'd160:8'd162]: c = mk(4'd11, 3'd4);
      [8'd163:8'd164]: c = mk(4'd10, 3'd7);
      [8'd165:8'd168]: c = mk(4'd11, 3'd5);
      [8'd169:8'd173]: c = mk(4'd12, 3'd4);
      [8'd174:8'd175]: c = mk(4'd11, 3'd6);
      [8'd176:8'd182]: c = mk(4'd12, 3'd5);
      [8'd183:8'd184]: c = mk(4'd13, 3'd4);
      [8'd185:8'd191]: c = mk(4'd12, 3'd6);
      [8'd192:8'd196]: c = mk(4'd13, 3'd5);
      [8'd197:8'd200]: c = mk(4'd12, 3'd7);
      [8'd201:8'd207]: c = mk(4'd13, 3'd6);
      [8'd208:8'd211]: c = mk(4'd14, 3'd5);
      [8'd212:8'd218]: c = mk(4'd13, 3'd7);
      [8'd219:8'd223]: c = mk(4'd14, 3'd6);
      [8'd224:8'd236]: c = mk(4'd14, 3'd7);
      [8'd237:8'd239]: c = mk(4'd15, 3'd6);
      default:         c = mk(4'd15, 3'd7);
    endcase
    return c;
  endfunction

endpackage

`default_nettype wire

@@ rtl/pvse_map_stage.sv @@
// input stage: registers the pulse/volume setting looked up from each sample
`default_nettype none

module pvse_map_stage
  import pvse_pkg::*;
(
  input  wire logic               clk,
  input  wire logic               rst_n,
  input  wire logic               in_valid,
  output logic                    in_ready,
  input  wire logic [SampleW-1:0] in_sample,
  output stage_t                  s1,
  input  wire logic               s1_take
);

  logic valid_r;
  cfg_t cfg_r;

  assign in_ready = !valid_r || s1_take;
  assign s1.valid = valid_r;
  assign s1.cfg   = cfg_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      valid_r <= 1'b0;
    end else if (in_ready) begin
      valid_r <= in_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (in_valid && in_ready) begin
      cfg_r <= map_sample(in_sample);
    end
  end

endmodule

`default_nettype wire

@@ rtl/pvse_flag_stage.sv @@
// result stage: transition check, midpoint chain and the output register
`default_nettype none

module pvse_flag_stage
  import pvse_pkg::*;
(
  input  wire logic              clk,
  input  wire logic              rst_n,
  input  wire stage_t            s1,
  output logic                   s1_take,
  output logic                   out_valid,
  input  wire logic              out_ready,
  output logic [PulseW-1:0]      out_pulse_level,
  output logic                   out_volume_first,
  output logic [VolW-1:0]        out_master_volume
);

  function automatic logic [7:0] mid_pt(input logic hi, input logic [3:0] p,
                                        input logic [2:0] v);
    logic [7:0] base;
    base = hi ? MidHigh : MidLow;
    if (v == VolMax && p == PulseMin) return base - MidLow;
    else if (v == VolMax && p == PulseMax) return base + MidLow;
    else return base;
  endfunction

  function automatic logic [1:0] pick(input logic [7:0] c, input logic [7:0] p,
                                      input logic [7:0] th);
    if (c < p) return (c <= th) ? 2'd0 : 2'd2;
    else return (p <= th) ? 2'd1 : 2'd3;
  endfunction

  function automatic logic [1:0] outside(input logic [7:0] c, input logic [7:0] p,
                                         input logic [7:0] l, input logic [7:0] r);
    if (c > l) return (p > l) ? pick(c, p, l + ThrUp) : 2'd1;
    else if (c > r) return (p > r) ? pick(c, p, r + ThrDown) : 2'd1;
    else return 2'd0;
  endfunction

  function automatic logic [1:0] window(input logic [7:0] c, input logic [7:0] p,
                                        input logic [7:0] l, input logic [7:0] r);
    if (c <= l && c >= r) return 2'd0;
    else if (p <= l && p >= r) return 2'd1;
    else return outside(c, p, l, r);
  endfunction

  cfg_t prev_r;
  logic started_r;
  logic out_valid_r;
  cfg_t out_cfg_r;
  logic out_vf_r;

  logic       trans_ok;
  logic       hi;
  logic [7:0] c8, ct, p8, pt;
  logic [1:0] chain;
  logic       vf_nxt;

  always_comb begin
    if (prev_r.pulse == s1.cfg.pulse || prev_r.vol == s1.cfg.vol) begin
      trans_ok = 1'b1;
    end else if (s1.cfg.pulse[3] && prev_r.pulse[3]) begin
      trans_ok = (s1.cfg.pulse > prev_r.pulse) == (s1.cfg.vol > prev_r.vol);
    end else if (!s1.cfg.pulse[3] && !prev_r.pulse[3]) begin
      trans_ok = (s1.cfg.pulse > prev_r.pulse) != (s1.cfg.vol > prev_r.vol);
    end else begin
      trans_ok = s1.cfg.vol > prev_r.vol;
    end
  end

  // all four points use the midpoint picked by the new pulse
  assign hi = s1.cfg.pulse[3];
  assign c8 = mid_pt(hi, s1.cfg.pulse, s1.cfg.vol);
  assign ct = mid_pt(hi, s1.cfg.pulse, prev_r.vol);
  assign p8 = mid_pt(hi, prev_r.pulse, prev_r.vol);
  assign pt = mid_pt(hi, prev_r.pulse, s1.cfg.vol);

  assign chain  = (c8 > p8) ? window(ct, pt, c8, p8) : window(ct, pt, p8, c8);
  assign vf_nxt = started_r && !trans_ok && chain[0];

  assign s1_take           = !out_valid_r || out_ready;
  assign out_valid         = out_valid_r;
  assign out_pulse_level   = out_cfg_r.pulse;
  assign out_volume_first  = out_vf_r;
  assign out_master_volume = out_cfg_r.vol;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
      started_r   <= 1'b0;
      prev_r      <= '0;
    end else if (s1_take) begin
      out_valid_r <= s1.valid;
      if (s1.valid) begin
        started_r <= 1'b1;
        prev_r    <= s1.cfg;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (s1.valid && s1_take) begin
      out_cfg_r <= s1.cfg;
      out_vf_r  <= vf_nxt;
    end
  end

endmodule

`default_nettype wire

@@ rtl/pulse_volume_sample_encoder.sv @@
// Pulse/volume sample encoder: each 8-bit sample becomes a 4-bit pulse level, a 3-bit
// master volume and a volume-first flag. One sample is taken per cycle while in_ready
// is high; each result passes the lookup register, then the flag and output register.
// in_ready follows out_ready combinationally when both stages hold a beat, so a stalled
// output holds at most two samples inside the block.
`default_nettype none

module pulse_volume_sample_encoder
  import pvse_pkg::*;
(
  input  wire logic               clk,
  input  wire logic               rst_n,
  input  wire logic               in_valid,
  output logic                    in_ready,
  input  wire logic [SampleW-1:0] in_sample,
  output logic                    out_valid,
  input  wire logic               out_ready,
  output logic [PulseW-1:0]       out_pulse_level,
  output logic                    out_volume_first,
  output logic [VolW-1:0]         out_master_volume
);

  stage_t s1;
  logic   s1_take;

  pvse_map_stage u_map (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_valid  (in_valid),
    .in_ready  (in_ready),
    .in_sample (in_sample),
    .s1        (s1),
    .s1_take   (s1_take)
  );

  pvse_flag_stage u_flag (
    .clk               (clk),
    .rst_n             (rst_n),
    .s1                (s1),
    .s1_take           (s1_take),
    .out_valid         (out_valid),
    .out_ready         (out_ready),
    .out_pulse_level   (out_pulse_level),
    .out_volume_first  (out_volume_first),
    .out_master_volume (out_master_volume)
  );

endmodule

`default_nettype wire

@@ rtl/pvse_chk.sv @@
// port-level checker for the pulse/volume encoder and its bind
`default_nettype none

module pvse_chk
  import pvse_pkg::*;
(
  input wire logic               clk,
  input wire logic               rst_n,
  input wire logic               in_valid,
  input wire logic               in_ready,
  input wire logic               out_valid,
  input wire logic               out_ready,
  input wire logic [PulseW-1:0]  out_pulse_level,
  input wire logic               out_volume_first,
  input wire logic [VolW-1:0]    out_master_volume
);

  logic [1:0] inflight_r;
  logic       seen_r;
  logic       in_acc;
  logic       out_acc;

  assign in_acc  = in_valid && in_ready;
  assign out_acc = out_valid && out_ready;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      inflight_r <= 2'd0;
      seen_r     <= 1'b0;
    end else begin
      inflight_r <= inflight_r + {1'b0, in_acc} - {1'b0, out_acc};
      if (out_acc) begin
        seen_r <= 1'b1;
      end
    end
  end

  // stalled result beat holds
  a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && !out_ready |=> out_valid && $stable(out_pulse_level)
      && $stable(out_volume_first) && $stable(out_master_volume))
    else $error("stalled result beat changed");

  a_no_phantom: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid |-> inflight_r != 2'd0)
    else $error("result beat without a sample");

  a_full_only: assert property (@(posedge clk) disable iff (!rst_n)
    !in_ready |-> inflight_r == 2'd2)
    else $error("input stalled while the pipeline has room");

  a_first_plain: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && !seen_r |-> !out_volume_first)
    else $error("first result after reset flagged volume first");

  a_mid_vol: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && (out_pulse_level == 4'd7 || out_pulse_level == 4'd8)
      |-> out_master_volume == 3'd0)
    else $error("center pulse level with nonzero volume");

endmodule

bind pulse_volume_sample_encoder pvse_chk u_pvse_chk (
  .clk               (clk),
  .rst_n             (rst_n),
  .in_valid          (in_valid),
  .in_ready          (in_ready),
  .out_valid         (out_valid),
  .out_ready         (out_ready),
  .out_pulse_level   (out_pulse_level),
  .out_volume_first  (out_volume_first),
  .out_master_volume (out_master_volume)
);

`default_nettype wire

@@ tb/tb_pulse_volume_sample_encoder.sv @@
// self-checking testbench for the pulse/volume sample encoder
`timescale 1ns / 1ps

module tb_pulse_volume_sample_encoder;
  import pvse_pkg::*;

  typedef struct packed {
    logic [PulseW-1:0] pulse_level;
    logic              volume_first;
    logic [VolW-1:0]   master_volume;
  } coded_sample_t;

  typedef struct packed {
    logic [SampleW-1:0] sample;
    logic               typed;
    coded_sample_t      res;
  } stim_row_t;

  localparam int NumLabels  = 60;
  localparam int NumRows    = 25;
  localparam int PhaseItems = 356;
  localparam int NumEdges   = 15;

  localparam logic [7:0] SpanLo [NumLabels] = '{
    8'd0,   8'd15,  8'd18,  8'd31,  8'd36,  8'd45,  8'd47,  8'd54,  8'd58,  8'd63,
    8'd70,  8'd72,  8'd79,  8'd81,  8'd86,  8'd90,  8'd92,  8'd95,  8'd99,  8'd104,
    8'd106, 8'd108, 8'd111, 8'd113, 8'd115, 8'd117, 8'd120, 8'd122, 8'd124, 8'd127,
    8'd128, 8'd129, 8'd131, 8'd133, 8'd135, 8'd138, 8'd140, 8'd142, 8'd144, 8'd147,
    8'd149, 8'd151, 8'd156, 8'd160, 8'd163, 8'd165, 8'd169, 8'd174, 8'd176, 8'd183,
    8'd185, 8'd192, 8'd197, 8'd201, 8'd208, 8'd210, 8'd219, 8'd224, 8'd237, 8'd240
  };
  localparam logic [7:0] SpanHi [NumLabels] = '{
    8'd14,  8'd17,  8'd30,  8'd35,  8'd44,  8'd46,  8'd53,  8'd57,  8'd62,  8'd69,
    8'd71,  8'd78,  8'd80,  8'd85,  8'd89,  8'd91,  8'd94,  8'd98,  8'd103, 8'd105,
    8'd107, 8'd110, 8'd112, 8'd114, 8'd116, 8'd119, 8'd121, 8'd123, 8'd126, 8'd127,
    8'd128, 8'd130, 8'd132, 8'd134, 8'd137, 8'd139, 8'd141, 8'd143, 8'd146, 8'd148,
    8'd150, 8'd155, 8'd159, 8'd162, 8'd164, 8'd168, 8'd173, 8'd175, 8'd182, 8'd184,
    8'd191, 8'd196, 8'd200, 8'd207, 8'd211, 8'd218, 8'd223, 8'd236, 8'd239, 8'd255
  };
  localparam logic [2:0] VolTab [30] = '{
    3'd7, 3'd6, 3'd7, 3'd6, 3'd7, 3'd5, 3'd6, 3'd7, 3'd5, 3'd6,
    3'd4, 3'd5, 3'd6, 3'd4, 3'd5, 3'd7, 3'd4, 3'd6, 3'd5, 3'd4,
    3'd2, 3'd7, 3'd6, 3'd5, 3'd4, 3'd3, 3'd2, 3'd1, 3'd0, 3'd0
  };
  localparam logic [3:0] PulseLoTab [30] = '{
    4'd0, 4'd0, 4'd1, 4'd1, 4'd2, 4'd1, 4'd2, 4'd3, 4'd2, 4'd3,
    4'd2, 4'd3, 4'd4, 4'd3, 4'd4, 4'd5, 4'd4, 4'd5, 4'd5, 4'd5,
    4'd4, 4'd6, 4'd6, 4'd6, 4'd6, 4'd6, 4'd6, 4'd6, 4'd6, 4'd7
  };
  localparam logic [3:0] PulseHiTab [30] = '{
    4'd15, 4'd15, 4'd14, 4'd14, 4'd13, 4'd14, 4'd13, 4'd12, 4'd13, 4'd12,
    4'd13, 4'd12, 4'd11, 4'd12, 4'd11, 4'd10, 4'd11, 4'd10, 4'd10, 4'd10,
    4'd11, 4'd9,  4'd9,  4'd9,  4'd9,  4'd9,  4'd9,  4'd9,  4'd9,  4'd8
  };

  // expected result typed in only for the first beat, the extremes and repeated settings
  localparam stim_row_t StimRows [NumRows] = '{
    {8'd0,   1'b1, 4'd0,  1'b0, 3'd7},
    {8'd255, 1'b1, 4'd15, 1'b0, 3'd7},
    {8'd240, 1'b1, 4'd15, 1'b0, 3'd7},
    {8'd210, 1'b0, 8'd0},
    {8'd211, 1'b1, 4'd14, 1'b0, 3'd5},
    {8'd212, 1'b0, 8'd0},
    {8'd14,  1'b0, 8'd0},
    {8'd15,  1'b0, 8'd0},
    {8'd127, 1'b0, 8'd0},
    {8'd128, 1'b0, 8'd0},
    {8'd126, 1'b0, 8'd0},
    {8'd129, 1'b0, 8'd0},
    {8'd237, 1'b0, 8'd0},
    {8'd0,   1'b0, 8'd0},
    {8'd239, 1'b0, 8'd0},
    {8'd36,  1'b0, 8'd0},
    {8'd146, 1'b0, 8'd0},
    {8'd147, 1'b0, 8'd0},
    {8'd127, 1'b0, 8'd0},
    {8'd255, 1'b0, 8'd0},
    {8'd128, 1'b0, 8'd0},
    {8'd0,   1'b0, 8'd0},
    {8'd224, 1'b0, 8'd0},
    {8'd106, 1'b0, 8'd0},
    {8'd163, 1'b0, 8'd0}
  };

  localparam logic [7:0] EdgeSamples [NumEdges] = '{
    8'd0, 8'd14, 8'd15, 8'd126, 8'd127, 8'd128, 8'd129, 8'd210,
    8'd211, 8'd212, 8'd236, 8'd237, 8'd239, 8'd240, 8'd255
  };

  localparam int SendIdle  [4] = '{0, 73, 0, 8};
  localparam int RecvStall [4] = '{0, 0, 73, 8};

  logic               clk = 1'b0;
  logic               rst_n;
  logic               in_valid;
  logic               in_ready;
  logic [SampleW-1:0] in_sample;
  logic               out_valid;
  logic               out_ready;
  logic [PulseW-1:0]  out_pulse_level;
  logic               out_volume_first;
  logic [VolW-1:0]    out_master_volume;

  coded_sample_t coded_q [$];
  coded_sample_t head;
  cfg_t          prev_setting;
  bit            have_prev;
  int            send_idle_pct;
  int            recv_stall_pct;
  int            samples_sent;
  int            results_checked;
  int            flags_seen;
  int            mismatches;

  pulse_volume_sample_encoder uut (
    .clk               (clk),
    .rst_n             (rst_n),
    .in_valid          (in_valid),
    .in_ready          (in_ready),
    .in_sample         (in_sample),
    .out_valid         (out_valid),
    .out_ready         (out_ready),
    .out_pulse_level   (out_pulse_level),
    .out_volume_first  (out_volume_first),
    .out_master_volume (out_master_volume)
  );

  always #10 clk = ~clk;

  function automatic int direction(input int x);
    return int'(x > 0) - int'(x < 0);
  endfunction

  function automatic logic [7:0] scaled_point(input int mid, input int pulse, input int vol);
    int t;
    int v;
    t = (pulse < 8) ? pulse - 7 : pulse - 8;
    v = (t / 7) * ((vol + 1) / 8);
    return 8'(mid + 127 * v);
  endfunction

  function automatic logic [1:0] threshold_pick(input logic [7:0] c, input logic [7:0] p,
                                                input logic [7:0] th);
    if (c < p) return (c <= th) ? 2'd0 : 2'd2;
    return (p <= th) ? 2'd1 : 2'd3;
  endfunction

  function automatic coded_sample_t encode_sample(input logic [SampleW-1:0] s);
    coded_sample_t res;
    cfg_t          cur;
    int            lab;
    int            pp;
    int            cp;
    int            pv;
    int            cv;
    int            mid;
    bit            step_ok;
    logic [7:0]    c8;
    logic [7:0]    ct;
    logic [7:0]    p8;
    logic [7:0]    pt;
    logic [7:0]    hi_pt;
    logic [7:0]    lo_pt;
    logic [1:0]    pick;
    lab = NumLabels - 1;
    for (int k = NumLabels - 1; k >= 0; k--) begin
      if (s >= SpanLo[k] && s <= SpanHi[k]) lab = k;
    end
    if (lab < 30) begin
      cur.pulse = PulseLoTab[lab];
      cur.vol   = VolTab[lab];
    end else begin
      cur.pulse = PulseHiTab[59 - lab];
      cur.vol   = VolTab[59 - lab];
    end
    res.pulse_level   = cur.pulse;
    res.master_volume = cur.vol;
    res.volume_first  = 1'b0;
    if (have_prev) begin
      pp = int'(prev_setting.pulse);
      cp = int'(cur.pulse);
      pv = int'(prev_setting.vol);
      cv = int'(cur.vol);
      if (pp == cp || pv == cv) step_ok = 1'b1;
      else if (cp > 7 && pp > 7) step_ok = direction(cp - pp) == direction(cv - pv);
      else if (cp < 8 && pp < 8) step_ok = direction(cp - pp) == direction(pv - cv);
      else step_ok = cv > pv;
      if (!step_ok) begin
        mid = (cp < 8) ? 127 : 128;
        c8 = scaled_point(mid, cp, cv);
        ct = scaled_point(mid, cp, pv);
        p8 = scaled_point(mid, pp, pv);
        pt = scaled_point(mid, pp, cv);
        if (c8 > p8) begin
          hi_pt = c8;
          lo_pt = p8;
        end else begin
          hi_pt = p8;
          lo_pt = c8;
        end
        if (ct <= hi_pt && ct >= lo_pt) begin
          res.volume_first = 1'b0;
        end else if (pt <= hi_pt && pt >= lo_pt) begin
          res.volume_first = 1'b1;
        end else if (ct > hi_pt) begin
          if (pt > hi_pt) begin
            pick = threshold_pick(ct, pt, hi_pt + 8'd16);
            res.volume_first = pick[0];
          end else begin
            res.volume_first = 1'b1;
          end
        end else if (ct > lo_pt) begin
          if (pt > lo_pt) begin
            pick = threshold_pick(ct, pt, lo_pt + 8'd240);
            res.volume_first = pick[0];
          end else begin
            res.volume_first = 1'b1;
          end
        end
      end
    end
    have_prev    = 1'b1;
    prev_setting = cur;
    return res;
  endfunction

  task automatic drive_sample(input logic [SampleW-1:0] s, input logic typed,
                              input coded_sample_t typed_res);
    coded_sample_t predicted;
    while (send_idle_pct != 0 && $urandom_range(0, 99) < send_idle_pct) begin
      in_valid <= 1'b0;
      @(posedge clk);
    end
    in_valid  <= 1'b1;
    in_sample <= s;
    @(posedge clk);
    while (!in_ready) @(posedge clk);
    predicted = encode_sample(s);
    coded_q.push_back(typed ? typed_res : predicted);
    samples_sent++;
  endtask

  task automatic drain_results();
    in_valid <= 1'b0;
    @(posedge clk);
    while (coded_q.size() != 0) @(posedge clk);
  endtask

  always @(posedge clk) begin
    out_ready <= (recv_stall_pct == 0) || ($urandom_range(0, 99) >= recv_stall_pct);
  end

  always @(posedge clk) begin
    if (rst_n && out_valid && out_ready) begin
      if (coded_q.size() == 0) begin
        mismatches++;
        if (mismatches <= 10)
          $display("unexpected beat: pulse=%0d vf=%0d vol=%0d", out_pulse_level,
                   out_volume_first, out_master_volume);
      end else begin
        head = coded_q.pop_front();
        results_checked++;
        if (head.volume_first) flags_seen++;
        if (out_pulse_level !== head.pulse_level || out_volume_first !== head.volume_first ||
            out_master_volume !== head.master_volume) begin
          mismatches++;
          if (mismatches <= 10)
            $display("beat %0d: expected pulse=%0d vf=%0d vol=%0d, got pulse=%0d vf=%0d vol=%0d",
                     results_checked, head.pulse_level, head.volume_first,
                     head.master_volume, out_pulse_level, out_volume_first,
                     out_master_volume);
        end
      end
    end
  end

  initial begin
    logic [SampleW-1:0] s;
    rst_n          <= 1'b0;
    in_valid       <= 1'b0;
    in_sample      <= '0;
    out_ready      <= 1'b0;
    send_idle_pct  = 0;
    recv_stall_pct = 0;
    have_prev      = 1'b0;
    prev_setting   = '0;
    repeat (12) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);
    for (int r = 0; r < NumRows; r++) begin
      drive_sample(StimRows[r].sample, StimRows[r].typed, StimRows[r].res);
    end
    for (int ph = 0; ph < 4; ph++) begin
      drain_results();
      send_idle_pct  = SendIdle[ph];
      recv_stall_pct = RecvStall[ph];
      for (int n = 0; n < PhaseItems; n++) begin
        if ($urandom_range(0, 3) == 0) s = EdgeSamples[$urandom_range(0, NumEdges - 1)];
        else s = 8'($urandom_range(0, 255));
        drive_sample(s, 1'b0, '0);
      end
    end
    drain_results();
    repeat (8) @(posedge clk);
    $display("%0d samples sent over four idle/stall mixes, %0d results checked",
             samples_sent, results_checked);
    $display("%0d results carried the volume-first flag, %0d mismatches",
             flags_seen, mismatches);
    if (mismatches == 0 && coded_q.size() == 0) begin
      $display("SCOREBOARD CLEAN");
    end else begin
      $display("SCOREBOARD MISMATCH");
    end
    $finish;
  end

  initial begin
    #10_000_000;
    $display("SCOREBOARD MISMATCH");
    $finish;
  end

endmodule

@@ filelist.f @@
rtl/pvse_pkg.sv
rtl/pvse_map_stage.sv
rtl/pvse_flag_stage.sv
rtl/pulse_volume_sample_encoder.sv
rtl/pvse_chk.sv
tb/tb_pulse_volume_sample_encoder.sv
